### src/label_key_value_checker_unit_defines.svh
// Assertion macros used by the label key/value checker's port-level checks.
// Depends on nothing; included by the checker module.
`ifndef LABEL_KEY_VALUE_CHECKER_UNIT_DEFINES_SVH
`define LABEL_KEY_VALUE_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/lkvc_pkg.sv
// Shared types, character constants and class functions for the label checker.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package lkvc_pkg;

	localparam int unsigned CountWidth = 8;

	localparam logic [7:0] CHAR_SLASH      = 8'h2F;
	localparam logic [7:0] CHAR_DASH       = 8'h2D;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CHAR_DOT        = 8'h2E;

	localparam logic [CountWidth-1:0] COUNT_MAX    = 8'd255;
	localparam logic [7:0]            LENGTH_RESET = 8'd63;

	// Configuration register indexes
	localparam logic REG_MAX_KEY_LENGTH   = 1'b0;
	localparam logic REG_MAX_VALUE_LENGTH = 1'b1;

	// Verdict codes, first failing check wins
	typedef enum logic [2:0] {
		FAULT_NONE         = 3'd0,
		FAULT_KEY_LENGTH   = 3'd1,
		FAULT_VALUE_LENGTH = 3'd2,
		FAULT_EMPTY_PREFIX = 3'd3,
		FAULT_EMPTY_NAME   = 3'd4,
		FAULT_BAD_NAME     = 3'd5,
		FAULT_BAD_VALUE    = 3'd6
	} fault_t;

	// One streamed character with its framing bits
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_value;
		logic       has_char;
		logic       is_last;
	} item_t;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]});
	endfunction

	function automatic logic is_allowed(input logic [7:0] c);
		return is_alnum(c) || (c == CHAR_DASH) || (c == CHAR_UNDERSCORE) ||
			(c == CHAR_DOT);
	endfunction

	function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
		return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
	endfunction

endpackage

### src/label_key_value_checker_unit.sv
// Label key/value checker: takes one character per transaction and gives one verdict
// per pair. An item is registered in the input register on acceptance and processed from
// there; when it ends a pair and the result register is free, its verdict is loaded into
// the result register. One item is accepted every cycle while in_stall is low. in_stall
// rises only when the held item ends a pair and the result register is full and stalled.
// Depends on lkvc_pkg and lkvc_tracker.
`timescale 1ns / 1ps

module label_key_value_checker_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       is_value,
	input  logic       has_char,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       pair_ok,
	output logic [2:0] fault_code,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import lkvc_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       out_valid_q;
	logic       pair_ok_q;
	fault_t     fault_q;
	fault_t     fault;
	logic       out_free;
	logic       advance;
	logic       accept;
	logic [7:0] max_key_length_q;
	logic [7:0] max_value_length_q;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!item_s1.is_last || out_free);
	assign in_stall = valid_s1 && item_s1.is_last && !out_free;
	assign accept   = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_key_length_q   <= LENGTH_RESET;
			max_value_length_q <= LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_KEY_LENGTH:   max_key_length_q   <= cfg_data;
				REG_MAX_VALUE_LENGTH: max_value_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{char_code: char_code, is_value: is_value,
				has_char: has_char, is_last: is_last};
		end
	end

	lkvc_tracker u_tracker (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.item             (item_s1),
		.max_key_length   (max_key_length_q),
		.max_value_length (max_value_length_q),
		.fault            (fault)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.is_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance && item_s1.is_last) begin
			fault_q   <= fault;
			pair_ok_q <= (fault == FAULT_NONE);
		end
	end

	assign out_valid  = out_valid_q;
	assign pair_ok    = pair_ok_q;
	assign fault_code = fault_q;

endmodule

### src/lkvc_tracker.sv
// Per-pair tracking state and verdict logic for the label checker.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  lkvc_pkg::item_t      item,
	input  logic [7:0]           max_key_length,
	input  logic [7:0]           max_value_length,
	output lkvc_pkg::fault_t     fault
);
	import lkvc_pkg::*;

	logic [CountWidth-1:0] key_count_q, key_count_d;
	logic [CountWidth-1:0] value_count_q, value_count_d;
	logic [CountWidth-1:0] name_count_q, name_count_d;
	logic slash_seen_q, slash_seen_d;
	logic prefix_empty_q, prefix_empty_d;
	logic name_first_alnum_q, name_first_alnum_d;
	logic name_last_alnum_q, name_last_alnum_d;
	logic name_chars_ok_q, name_chars_ok_d;
	logic value_first_alnum_q, value_first_alnum_d;
	logic value_last_alnum_q, value_last_alnum_d;
	logic value_chars_ok_q, value_chars_ok_d;
	logic an, allowed;

	assign an      = is_alnum(item.char_code);
	assign allowed = is_allowed(item.char_code);

	// Take the current character into the key or value state.
	always_comb begin
		key_count_d         = key_count_q;
		value_count_d       = value_count_q;
		name_count_d        = name_count_q;
		slash_seen_d        = slash_seen_q;
		prefix_empty_d      = prefix_empty_q;
		name_first_alnum_d  = name_first_alnum_q;
		name_last_alnum_d   = name_last_alnum_q;
		name_chars_ok_d     = name_chars_ok_q;
		value_first_alnum_d = value_first_alnum_q;
		value_last_alnum_d  = value_last_alnum_q;
		value_chars_ok_d    = value_chars_ok_q;
		if (item.has_char && item.is_value) begin
			if (value_count_q == '0) begin
				value_first_alnum_d = an;
			end
			value_last_alnum_d = an;
			value_chars_ok_d   = value_chars_ok_q && allowed;
			value_count_d      = sat_inc(value_count_q);
		end else if (item.has_char) begin
			// Only the first slash splits prefix from name.
			if (!slash_seen_q && (item.char_code == CHAR_SLASH)) begin
				slash_seen_d   = 1'b1;
				prefix_empty_d = (key_count_q == '0);
			end else begin
				if (name_count_q == '0) begin
					name_first_alnum_d = an;
				end
				name_last_alnum_d = an;
				name_chars_ok_d   = name_chars_ok_q && allowed;
				name_count_d      = sat_inc(name_count_q);
			end
			key_count_d = sat_inc(key_count_q);
		end
	end

	// Verdict on the state including the current character.
	always_comb begin
		if ((key_count_d == '0) || (key_count_d > max_key_length)) begin
			fault = FAULT_KEY_LENGTH;
		end else if (value_count_d > max_value_length) begin
			fault = FAULT_VALUE_LENGTH;
		end else if (slash_seen_d && prefix_empty_d) begin
			fault = FAULT_EMPTY_PREFIX;
		end else if (name_count_d == '0) begin
			fault = FAULT_EMPTY_NAME;
		end else if (!name_first_alnum_d || !name_last_alnum_d || !name_chars_ok_d) begin
			fault = FAULT_BAD_NAME;
		end else if ((value_count_d != '0) &&
			(!value_first_alnum_d || !value_last_alnum_d || !value_chars_ok_d)) begin
			fault = FAULT_BAD_VALUE;
		end else begin
			fault = FAULT_NONE;
		end
	end

	// State update; the verdict step returns everything to its cleared value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q         <= '0;
			value_count_q       <= '0;
			name_count_q        <= '0;
			slash_seen_q        <= 1'b0;
			prefix_empty_q      <= 1'b0;
			name_first_alnum_q  <= 1'b0;
			name_last_alnum_q   <= 1'b0;
			name_chars_ok_q     <= 1'b1;
			value_first_alnum_q <= 1'b0;
			value_last_alnum_q  <= 1'b0;
			value_chars_ok_q    <= 1'b1;
		end else if (step && item.is_last) begin
			key_count_q         <= '0;
			value_count_q       <= '0;
			name_count_q        <= '0;
			slash_seen_q        <= 1'b0;
			prefix_empty_q      <= 1'b0;
			name_first_alnum_q  <= 1'b0;
			name_last_alnum_q   <= 1'b0;
			name_chars_ok_q     <= 1'b1;
			value_first_alnum_q <= 1'b0;
			value_last_alnum_q  <= 1'b0;
			value_chars_ok_q    <= 1'b1;
		end else if (step) begin
			key_count_q         <= key_count_d;
			value_count_q       <= value_count_d;
			name_count_q        <= name_count_d;
			slash_seen_q        <= slash_seen_d;
			prefix_empty_q      <= prefix_empty_d;
			name_first_alnum_q  <= name_first_alnum_d;
			name_last_alnum_q   <= name_last_alnum_d;
			name_chars_ok_q     <= name_chars_ok_d;
			value_first_alnum_q <= value_first_alnum_d;
			value_last_alnum_q  <= value_last_alnum_d;
			value_chars_ok_q    <= value_chars_ok_d;
		end
	end

endmodule

### src/lkvc_checker.sv
// Port-level checks for the label key/value checker, bound to the top level.
// Depends on lkvc_pkg and label_key_value_checker_unit_defines.svh.
`timescale 1ns / 1ps
`include "label_key_value_checker_unit_defines.svh"

module lkvc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       pair_ok,
	input logic [2:0] fault_code
);
	import lkvc_pkg::*;

	// A stalled result transaction keeps its contents.
	`LKVC_ASSERT_NXT(a_result_held, clk, arst_n, out_valid && out_stall, out_valid && $stable(pair_ok) && $stable(fault_code), "stalled result changed")

	// pair_ok agrees with the fault code.
	`LKVC_ASSERT_IMP(a_ok_matches, clk, arst_n, out_valid, pair_ok == (fault_code == FAULT_NONE), "pair_ok disagrees with fault_code")

	// Only defined fault codes appear.
	`LKVC_ASSERT_IMP(a_code_range, clk, arst_n, out_valid, fault_code <= FAULT_BAD_VALUE, "undefined fault code")

	// Input side only stalls behind a full, stalled result register.
	`LKVC_ASSERT_IMP(a_stall_cause, clk, arst_n, !out_valid || !out_stall, !in_stall, "input stalled without output back-pressure")

	// Back-pressure on the input persists while the output stays blocked.
	`LKVC_ASSERT_NXT(a_stall_holds, clk, arst_n, in_stall && in_valid, in_stall || !out_stall, "input stall dropped while output still blocked")

endmodule

bind label_key_value_checker_unit lkvc_checker u_lkvc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pair_ok    (pair_ok),
	.fault_code (fault_code)
);

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for label_key_value_checker_unit: streams label pairs and checks verdicts.
// Depends on lkvc_pkg and the checker RTL; needs no files or arguments.

module tb;
	import lkvc_pkg::*;

	localparam int unsigned RunLimit     = 400000;
	localparam int unsigned SettleCycles = 4;

	typedef struct {
		logic   ok;
		fault_t code;
	} verdict_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [7:0] char_code  = 8'd0;
	logic       is_value   = 1'b0;
	logic       has_char   = 1'b0;
	logic       is_last    = 1'b0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic       pair_ok;
	logic [2:0] fault_code;
	logic       cfg_we     = 1'b0;
	logic       cfg_index  = 1'b0;
	logic [7:0] cfg_data   = 8'd0;

	int unsigned cycle_count   = 0;
	int unsigned fail_count    = 0;
	int unsigned chars_sent    = 0;
	int unsigned verdicts_seen = 0;
	int unsigned pairs_passed  = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned hold_left     = 0;

	// Predicted register contents and per-pair tracking.
	logic [7:0] limit_key   = LENGTH_RESET;
	logic [7:0] limit_value = LENGTH_RESET;
	logic [7:0] key_len     = 8'd0;
	logic [7:0] val_len     = 8'd0;
	logic [7:0] name_len    = 8'd0;
	logic       split_seen   = 1'b0;
	logic       prefix_blank = 1'b0;
	logic       name_head    = 1'b0;
	logic       name_tail    = 1'b0;
	logic       name_clean   = 1'b1;
	logic       val_head     = 1'b0;
	logic       val_tail     = 1'b0;
	logic       val_clean    = 1'b1;

	verdict_t expected_verdicts[$];
	verdict_t want_verdict;

	label_key_value_checker_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.is_value   (is_value),
		.has_char   (has_char),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pair_ok    (pair_ok),
		.fault_code (fault_code),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RunLimit) begin
			$display("%0t: run limit of %0d cycles reached", $time, RunLimit);
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: a counted hold-off takes priority over random stalling.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare every accepted verdict with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			verdicts_seen++;
			if (expected_verdicts.size() == 0) begin
				fail_count++;
				$display("%0t: verdict with none expected: pair_ok %0b fault_code %0d",
					$time, pair_ok, fault_code);
			end else begin
				want_verdict = expected_verdicts.pop_front();
				if (pair_ok !== want_verdict.ok) begin
					fail_count++;
					$display("%0t: pair_ok expected %0b actual %0b",
						$time, want_verdict.ok, pair_ok);
				end
				if (fault_code !== want_verdict.code) begin
					fail_count++;
					$display("%0t: fault_code expected %0d (%s) actual %0d",
						$time, want_verdict.code, want_verdict.code.name(), fault_code);
				end
			end
		end
	end

	function automatic logic letter_or_digit(input logic [7:0] c);
		// Lower case, upper case, then digits.
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic label_char(input logic [7:0] c);
		return letter_or_digit(c) || c == CHAR_DASH || c == CHAR_UNDERSCORE || c == CHAR_DOT;
	endfunction

	function automatic logic [7:0] count_up(input logic [7:0] n);
		return (n == COUNT_MAX) ? n : n + 8'd1;
	endfunction

	task automatic clear_pair_track();
		key_len      = 8'd0;
		val_len      = 8'd0;
		name_len     = 8'd0;
		split_seen   = 1'b0;
		prefix_blank = 1'b0;
		name_head    = 1'b0;
		name_tail    = 1'b0;
		name_clean   = 1'b1;
		val_head     = 1'b0;
		val_tail     = 1'b0;
		val_clean    = 1'b1;
	endtask

	// Fold one real character into the running pair.
	task automatic absorb_char(input logic [7:0] c, input logic to_value);
		if (to_value) begin
			if (val_len == 0)
				val_head = letter_or_digit(c);
			val_tail = letter_or_digit(c);
			if (!label_char(c))
				val_clean = 1'b0;
			val_len = count_up(val_len);
		end else if (!split_seen && c == CHAR_SLASH) begin
			// Only the first slash splits prefix from name.
			split_seen   = 1'b1;
			prefix_blank = (key_len == 0);
			key_len      = count_up(key_len);
		end else begin
			if (name_len == 0)
				name_head = letter_or_digit(c);
			name_tail = letter_or_digit(c);
			if (!label_char(c))
				name_clean = 1'b0;
			name_len = count_up(name_len);
			key_len  = count_up(key_len);
		end
	endtask

	// The first failing check, in priority order, names the fault.
	function automatic fault_t judge_pair();
		if (key_len == 0 || key_len > limit_key)
			return FAULT_KEY_LENGTH;
		if (val_len > limit_value)
			return FAULT_VALUE_LENGTH;
		if (split_seen && prefix_blank)
			return FAULT_EMPTY_PREFIX;
		if (name_len == 0)
			return FAULT_EMPTY_NAME;
		if (!name_head || !name_tail || !name_clean)
			return FAULT_BAD_NAME;
		if (val_len != 0 && (!val_head || !val_tail || !val_clean))
			return FAULT_BAD_VALUE;
		return FAULT_NONE;
	endfunction

	function automatic logic [7:0] rand_alnum();
		int unsigned pick;
		pick = $urandom_range(61);
		if (pick < 10)
			return 8'(8'h30 + pick);
		if (pick < 36)
			return 8'(8'h41 + pick - 10);
		return 8'(8'h61 + pick - 36);
	endfunction

	function automatic logic [7:0] rand_label_char();
		case ($urandom_range(9))
			0: return CHAR_DASH;
			1: return CHAR_UNDERSCORE;
			2: return CHAR_DOT;
			default: return rand_alnum();
		endcase
	endfunction

	// Offer one transaction, wait for its acceptance, then update the prediction.
	task automatic send_item(input logic [7:0] c, input logic v, input logic h, input logic l);
		fault_t code;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		is_value  <= v;
		has_char  <= h;
		is_last   <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (h || l)
			chars_sent++;
		if (h)
			absorb_char(c, v);
		if (l) begin
			code = judge_pair();
			expected_verdicts.push_back('{code == FAULT_NONE, code});
			if (code == FAULT_NONE)
				pairs_passed++;
			clear_pair_track();
		end
	endtask

	task automatic end_marker();
		send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 1'b1);
	endtask

	task automatic send_text(input string s, input logic v, input logic end_pair);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], v, 1'b1, end_pair && (i == s.len() - 1));
	endtask

	// A well-formed run of n characters with random content, no verdict.
	task automatic send_long(input logic v, input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_item((i == 0 || i == n - 1) ? rand_alnum() : rand_label_char(), v, 1'b1, 1'b0);
	endtask

	// Stop offering and wait until every verdict is in and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_KEY_LENGTH)
			limit_key = val;
		else
			limit_value = val;
	endtask

	// One random pair: mostly well formed with occasional damage, otherwise noise.
	task automatic send_random_pair();
		logic [7:0]  key_chars[$];
		logic [7:0]  value_chars[$];
		logic [7:0]  c;
		int unsigned n;
		logic        mixed;
		logic        close_on_char;
		logic        from_value;
		logic        closing;
		logic        closed;
		closed = 1'b0;
		if ($urandom_range(99) < 75) begin
			if ($urandom_range(3) == 0) begin
				n = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 5);
				repeat (n) key_chars.push_back(rand_label_char());
				key_chars.push_back(CHAR_SLASH);
			end
			n = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
			for (int unsigned i = 0; i < n; i++)
				key_chars.push_back((i == 0 || i == n - 1) ? rand_alnum() : rand_label_char());
			n = $urandom_range(0, 12);
			for (int unsigned i = 0; i < n; i++)
				value_chars.push_back((i == 0 || i == n - 1) ? rand_alnum() : rand_label_char());
			// Damage one character now and then.
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(3))
					0: c = CHAR_SLASH;
					1: c = CHAR_DOT;
					default: c = 8'($urandom_range(255));
				endcase
				if ($urandom_range(1) == 0 && key_chars.size() != 0)
					key_chars[$urandom_range(key_chars.size() - 1)] = c;
				else if (value_chars.size() != 0)
					value_chars[$urandom_range(value_chars.size() - 1)] = c;
			end
		end else begin
			repeat ($urandom_range(8)) key_chars.push_back(8'($urandom_range(255)));
			repeat ($urandom_range(8)) value_chars.push_back(8'($urandom_range(255)));
		end
		mixed         = ($urandom_range(4) == 0);
		close_on_char = 1'($urandom_range(1));
		while (key_chars.size() + value_chars.size() != 0) begin
			if (key_chars.size() == 0)
				from_value = 1'b1;
			else if (value_chars.size() == 0)
				from_value = 1'b0;
			else
				from_value = mixed ? 1'($urandom_range(1)) : 1'b0;
			c = from_value ? value_chars.pop_front() : key_chars.pop_front();
			closing = close_on_char && (key_chars.size() + value_chars.size() == 0);
			// An occasional transaction that carries nothing.
			if ($urandom_range(19) == 0)
				send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 1'b0);
			send_item(c, from_value, 1'b1, closing);
			closed = closing;
		end
		if (!closed)
			end_marker();
	endtask

	// Hand-picked pairs: every fault code but the value-length one, and each corner of the syntax.
	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct     = 0;
		// A one-letter key whose character rides on the closing transaction.
		send_text("a", 1'b0, 1'b1);
		// A bare closing marker leaves the key empty.
		end_marker();
		send_text("/x", 1'b0, 1'b1);
		send_text("p/", 1'b0, 1'b1);
		// A second slash is just a bad name character.
		send_text("p/a/", 1'b0, 1'b1);
		send_text("Z9", 1'b0, 1'b0);
		send_text("-x", 1'b1, 1'b1);
		// Interleaved streams, with an empty transaction in the middle.
		send_text("v", 1'b1, 1'b0);
		send_text("k", 1'b0, 1'b0);
		send_item(8'hA5, 1'b1, 1'b0, 1'b0);
		send_text("w", 1'b1, 1'b0);
		end_marker();
		// Byte zero and the top byte are ordinary bad characters.
		send_text("k", 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1, 1'b1);
		send_item(8'h80, 1'b0, 1'b1, 1'b1);
		send_text("a-_.Z", 1'b0, 1'b0);
		send_text("9", 1'b1, 1'b1);
		drain();
	endtask

	// Pairs at and beyond the length limits, limits of zero, and a write in the middle of a pair.
	task automatic test_register_limits();
		write_reg(REG_MAX_KEY_LENGTH, 8'd1);
		write_reg(REG_MAX_VALUE_LENGTH, 8'd1);
		send_text("ab", 1'b0, 1'b1);
		send_text("a", 1'b0, 1'b0);
		send_text("bc", 1'b1, 1'b1);
		send_text("a", 1'b0, 1'b0);
		send_text("b", 1'b1, 1'b1);
		write_reg(REG_MAX_KEY_LENGTH, 8'd0);
		send_text("a", 1'b0, 1'b1);
		write_reg(REG_MAX_KEY_LENGTH, 8'd200);
		write_reg(REG_MAX_VALUE_LENGTH, 8'd0);
		send_text("a", 1'b0, 1'b0);
		send_text("b", 1'b1, 1'b1);
		send_text("a", 1'b0, 1'b1);
		write_reg(REG_MAX_VALUE_LENGTH, 8'd200);
		// The limit in force when the verdict is formed is the one that counts.
		send_text("abc", 1'b0, 1'b0);
		write_reg(REG_MAX_KEY_LENGTH, 8'd2);
		end_marker();
		send_text("abc", 1'b0, 1'b0);
		write_reg(REG_MAX_KEY_LENGTH, 8'd3);
		end_marker();
		drain();
	endtask

	// Streams past 255 characters, where the length counters saturate.
	task automatic test_long_streams();
		send_idle_pct = 20;
		stall_pct     = 20;
		write_reg(REG_MAX_KEY_LENGTH, 8'd255);
		write_reg(REG_MAX_VALUE_LENGTH, 8'd255);
		send_long(1'b0, 260);
		end_marker();
		send_long(1'b0, 5);
		send_long(1'b1, 260);
		end_marker();
		drain();
	endtask

	task automatic test_random_phase(input int unsigned idle_pct, input int unsigned hold_pct,
		input logic [7:0] key_limit, input logic [7:0] value_limit, input int unsigned target);
		int unsigned first;
		write_reg(REG_MAX_KEY_LENGTH, key_limit);
		write_reg(REG_MAX_VALUE_LENGTH, value_limit);
		send_idle_pct = idle_pct;
		stall_pct     = hold_pct;
		first         = chars_sent;
		while (chars_sent - first < target)
			send_random_pair();
		drain();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_output_hold_off();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_left    <= 300;
		repeat (10) send_random_pair();
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		clear_pair_track();
		test_directed();
		test_register_limits();
		test_long_streams();
		test_random_phase(0, 0, 8'd16, 8'd12, 60);
		test_random_phase(58, 0, 8'd200, 8'd200, 60);
		test_random_phase(0, 58, 8'd10, 8'd1, 60);
		test_random_phase(16, 16, 8'd7, 8'd200, 60);
		test_output_hold_off();
		drain();
		repeat (8) @(posedge clk);
		$display("Checked %0d verdicts from %0d character and marker transactions, %0d well formed.",
			verdicts_seen, chars_sent, pairs_passed);
		$display("Covered all fault codes, limits from 0 to 255, saturation, stalls and a hold-off.");
		if (fail_count == 0 && expected_verdicts.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
